/* design/tcw_pkg.sv */
package tcw_pkg;

	// Screen geometry and field widths are fixed by the interface widths.
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;
	localparam int CHAR_W = 8;
	localparam int CFG_W  = 8;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

	typedef enum logic [1:0] {
		ACT_PUT,
		ACT_SET,
		ACT_MOVE,
		ACT_READ
	} act_t;

	typedef enum logic [1:0] {
		REG_ATTR,
		REG_SCROLL_EN,
		REG_SCROLL_TOP,
		REG_SCROLL_END
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_COPY,
		BK_BLANK
	} back_state_t;

	// One classified command from the front end to the screen store.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [CELL_W-1:0] wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              scroll;
		logic [ADDR_W-1:0] reg_first;
		logic [ADDR_W-1:0] reg_last;
		logic [COL_W-1:0]  cur_x;
		logic [ROW_W-1:0]  cur_y;
		logic [ADDR_W-1:0] cur_off;
	} cmd_t;

endpackage

/* design/text_console_writer.sv */
// Text console writer: an 80x25 screen of 16-bit cells (character in the low byte,
// attribute in the high byte) with a cursor, driven by put-character, set-cursor,
// move-cursor and read-cell transactions, one result per transaction. After reset
// the screen store is swept to blank cells, during which in_ready stays low;
// configuration writes are taken throughout. The front end classifies a transaction
// combinationally, updates the cursor and hands a command to a two-entry queue.
// The back end, limited by the single write port of the screen memory, finishes a
// print, set or move or a read past the end of the screen in its idle state, and a
// read of a cell on the screen in a read state. A scroll takes the command, copies
// each cell of the region above its last row from the row below, finishes the last
// copy when there is one, and blanks the 80 cells of the last row.
module text_console_writer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [7:0]         char_code,
	input  logic signed [7:0]  pos_x,
	input  logic signed [7:0]  pos_y,
	input  logic [10:0]        read_address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [6:0]         cursor_x,
	output logic [4:0]         cursor_y,
	output logic [10:0]        cursor_offset,
	output logic [15:0]        cell_data,
	output logic               scrolled
);
	import tcw_pkg::*;

	logic clearing;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic head_valid;
	cmd_t push_data;
	cmd_t head_data;

	tcw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.char_code    (char_code),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.read_address (read_address),
		.clearing     (clearing),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (push_data)
	);

	tcw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	tcw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_data     (head_data),
		.pop           (q_pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cursor_x      (cursor_x),
		.cursor_y      (cursor_y),
		.cursor_offset (cursor_offset),
		.cell_data     (cell_data),
		.scrolled      (scrolled)
	);

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!in_ready && !out_valid && !head_valid))
		else $error("transaction activity during the clearing sweep");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_offset ==
			ADDR_W'(ADDR_W'(cursor_y) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_x))))
		else $error("cursor offset does not match cursor position");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((cursor_x < COL_W'(COLUMNS)) && (cursor_y < ROW_W'(ROWS))))
		else $error("cursor outside the screen");

	a_pop_ready: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> head_valid)
		else $error("command taken from an empty queue");

endmodule

/* design/tcw_front.sv */
module tcw_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [1:0]               cfg_index,
	input  logic [tcw_pkg::CFG_W-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               action,
	input  logic [7:0]               char_code,
	input  logic signed [7:0]        pos_x,
	input  logic signed [7:0]        pos_y,
	input  logic [10:0]              read_address,
	input  logic                     clearing,
	input  logic                     q_full,
	output logic                     q_push,
	output tcw_pkg::cmd_t            q_data
);
	import tcw_pkg::*;

	logic [ATTR_W-1:0] attr_q;
	logic              scroll_en_q;
	logic [ROW_W-1:0]  top_q;
	logic [ROW_W-1:0]  end_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic [ROW_W-1:0]  top_eff;
	logic [ROW_W-1:0]  end_lo;
	logic [ROW_W-1:0]  end_eff;
	logic [ROW_W-1:0]  last_row;
	logic [COL_W-1:0]  tab_sum;
	logic [COL_W-1:0]  pc_col;
	logic [ROW_W-1:0]  pc_row;
	logic              pc_write;
	logic              pc_scroll;
	logic [COL_W-1:0]  nx_col;
	logic [ROW_W-1:0]  nx_row;
	act_t              act;

	// Reduces a non-negative value below 8*COLUMNS to a column.
	function automatic logic [COL_W-1:0] wrap_col(input logic [9:0] v);
		logic [9:0] t;
		t = v;
		if (t >= 10'(4 * COLUMNS)) t = t - 10'(4 * COLUMNS);
		if (t >= 10'(2 * COLUMNS)) t = t - 10'(2 * COLUMNS);
		if (t >= 10'(COLUMNS)) t = t - 10'(COLUMNS);
		return t[COL_W-1:0];
	endfunction

	// Reduces a non-negative value below 16*ROWS to a row.
	function automatic logic [ROW_W-1:0] wrap_row(input logic [8:0] v);
		logic [8:0] t;
		t = v;
		if (t >= 9'(8 * ROWS)) t = t - 9'(8 * ROWS);
		if (t >= 9'(4 * ROWS)) t = t - 9'(4 * ROWS);
		if (t >= 9'(2 * ROWS)) t = t - 9'(2 * ROWS);
		if (t >= 9'(ROWS)) t = t - 9'(ROWS);
		return t[ROW_W-1:0];
	endfunction

	assign in_ready = !q_full && !clearing;
	assign q_push   = in_valid && in_ready;
	assign act      = act_t'(action);

	always_comb begin
		top_eff  = (top_q > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : top_q;
		end_lo   = (end_q <= top_eff) ? ROW_W'(top_eff + 1'b1) : end_q;
		end_eff  = (end_lo > ROW_W'(ROWS)) ? ROW_W'(ROWS) : end_lo;
		last_row = ROW_W'(end_eff - 1'b1);

		pc_col   = col_q;
		pc_row   = row_q;
		pc_write = 1'b0;
		tab_sum  = COL_W'(col_q + COL_W'(8));
		unique case (char_code)
			CH_BACKSPACE: begin
				if (col_q != '0) pc_col = COL_W'(col_q - 1'b1);
			end
			CH_TAB: pc_col = {tab_sum[COL_W-1:3], 3'b000};
			CH_RETURN: pc_col = '0;
			CH_NEWLINE: begin
				pc_col = '0;
				pc_row = ROW_W'(row_q + 1'b1);
			end
			default: begin
				pc_write = 1'b1;
				pc_col   = COL_W'(col_q + 1'b1);
			end
		endcase
		if (pc_col >= COL_W'(COLUMNS)) begin
			pc_col = '0;
			pc_row = ROW_W'(pc_row + 1'b1);
		end
		// A row at or past the region end is held on the last row of the region.
		pc_scroll = 1'b0;
		if (pc_row >= end_eff) begin
			pc_row    = last_row;
			pc_scroll = scroll_en_q;
		end

		unique case (act)
			ACT_PUT: begin
				nx_col = pc_col;
				nx_row = pc_row;
			end
			ACT_SET: begin
				nx_col = wrap_col({{2{pos_x[7]}}, pos_x} + 10'(2 * COLUMNS));
				nx_row = wrap_row({pos_y[7], pos_y} + 9'(6 * ROWS));
			end
			ACT_MOVE: begin
				nx_col = wrap_col({3'b000, col_q} + {{2{pos_x[7]}}, pos_x}
					+ 10'(2 * COLUMNS));
				nx_row = wrap_row({4'b0000, row_q} + {pos_y[7], pos_y} + 9'(6 * ROWS));
			end
			ACT_READ: begin
				nx_col = col_q;
				nx_row = row_q;
			end
			default: begin
				nx_col = col_q;
				nx_row = row_q;
			end
		endcase

		q_data.wr_en     = (act == ACT_PUT) && pc_write;
		q_data.wr_addr   = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q));
		q_data.wr_data   = {attr_q, char_code};
		q_data.rd_en     = (act == ACT_READ) && (read_address < ADDR_W'(CELLS));
		q_data.rd_addr   = read_address;
		q_data.scroll    = (act == ACT_PUT) && pc_scroll;
		q_data.reg_first = ADDR_W'(ADDR_W'(top_eff) * ADDR_W'(COLUMNS));
		q_data.reg_last  = ADDR_W'(ADDR_W'(last_row) * ADDR_W'(COLUMNS));
		q_data.cur_x     = nx_col;
		q_data.cur_y     = nx_row;
		q_data.cur_off   = ADDR_W'(ADDR_W'(nx_row) * ADDR_W'(COLUMNS) + ADDR_W'(nx_col));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= ATTR_W'(7);
			scroll_en_q <= 1'b1;
			top_q       <= '0;
			end_q       <= ROW_W'(ROWS);
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ATTR:       attr_q      <= cfg_data[ATTR_W-1:0];
				REG_SCROLL_EN:  scroll_en_q <= cfg_data[0];
				REG_SCROLL_TOP: top_q       <= cfg_data[ROW_W-1:0];
				REG_SCROLL_END: end_q       <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			col_q <= nx_col;
			row_q <= nx_row;
		end
	end

endmodule

/* design/tcw_queue.sv */
module tcw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output tcw_pkg::cmd_t head_data
);
	import tcw_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) count_q <= CNT_W'(count_q + 1'b1);
			else if (pop && !push) count_q <= CNT_W'(count_q - 1'b1);
		end
	end

endmodule

/* design/tcw_back.sv */
module tcw_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  tcw_pkg::cmd_t head_data,
	output logic          pop,
	output logic          clearing,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [6:0]    cursor_x,
	output logic [4:0]    cursor_y,
	output logic [10:0]   cursor_offset,
	output logic [15:0]   cell_data,
	output logic          scrolled
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;

	back_state_t       state_q, state_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	cmd_t              cmd_q;
	logic              cap;
	logic              pend_s1, pend_d;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;

	logic              out_free;
	logic              load_out;
	cmd_t              res_src;
	logic [CELL_W-1:0] res_cell;

	logic              out_valid_q;
	logic [COL_W-1:0]  out_x_q;
	logic [ROW_W-1:0]  out_y_q;
	logic [ADDR_W-1:0] out_off_q;
	logic [CELL_W-1:0] out_cell_q;
	logic              out_scr_q;

	assign out_free      = !out_valid_q || out_ready;
	assign clearing      = (state_q == BK_CLEAR);
	assign out_valid     = out_valid_q;
	assign cursor_x      = out_x_q;
	assign cursor_y      = out_y_q;
	assign cursor_offset = out_off_q;
	assign cell_data     = out_cell_q;
	assign scrolled      = out_scr_q;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pop       = 1'b0;
		cap       = 1'b0;
		pend_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = BLANK_CELL;
		mem_raddr = head_data.rd_addr;
		load_out  = 1'b0;
		res_src   = cmd_q;
		res_cell  = '0;
		unique case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
				if (cnt_q == ADDR_W'(CELLS - 1)) begin
					state_d = BK_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = ADDR_W'(cnt_q + 1'b1);
				end
			end
			BK_IDLE: begin
				// A command is taken only when its result has a place to go.
				if (head_valid && out_free) begin
					pop       = 1'b1;
					cap       = 1'b1;
					mem_we    = head_data.wr_en;
					mem_waddr = head_data.wr_addr;
					mem_wdata = head_data.wr_data;
					if (head_data.rd_en) begin
						state_d = BK_READ;
					end else if (head_data.scroll) begin
						if (head_data.reg_first == head_data.reg_last) begin
							state_d = BK_BLANK;
							cnt_d   = head_data.reg_last;
						end else begin
							state_d = BK_COPY;
							cnt_d   = head_data.reg_first;
						end
					end else begin
						load_out = 1'b1;
						res_src  = head_data;
					end
				end
			end
			BK_READ: begin
				load_out = 1'b1;
				res_cell = rdata_q;
				state_d  = BK_IDLE;
			end
			BK_COPY: begin
				// Each cell is read one row below and written back in the next cycle.
				mem_raddr = ADDR_W'(cnt_q + ADDR_W'(COLUMNS));
				pend_d    = 1'b1;
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = wr_addr_s1;
					mem_wdata = rdata_q;
				end
				cnt_d = ADDR_W'(cnt_q + 1'b1);
				if (ADDR_W'(cnt_q + 1'b1) == cmd_q.reg_last) state_d = BK_BLANK;
			end
			BK_BLANK: begin
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = wr_addr_s1;
					mem_wdata = rdata_q;
				end else begin
					mem_we = 1'b1;
					if (cnt_q == ADDR_W'(cmd_q.reg_last + ADDR_W'(COLUMNS - 1))) begin
						load_out = 1'b1;
						state_d  = BK_IDLE;
					end else begin
						cnt_d = ADDR_W'(cnt_q + 1'b1);
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (cap) cmd_q <= head_data;
		wr_addr_s1 <= cnt_q;
		if (load_out) begin
			out_x_q    <= res_src.cur_x;
			out_y_q    <= res_src.cur_y;
			out_off_q  <= res_src.cur_off;
			out_cell_q <= res_cell;
			out_scr_q  <= res_src.scroll;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
